>>> rtl/chol_pkg.sv
// ----------------------------------------------------------------------------
// chol_pkg
// Shared types and constants for the Cholesky factorization block.
// ----------------------------------------------------------------------------
package chol_pkg;

  localparam int DATA_W    = 32;
  localparam int WIDE_W    = 64;
  localparam int IDX_W     = 3;
  localparam int SIZE_W    = 4;
  localparam int CNT_W     = 7;
  localparam int MAX_N_DEF = 8;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // controller states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MRD,
    ST_MMUL,
    ST_MACC,
    ST_ARD,
    ST_ASUB,
    ST_CHK,
    ST_SQRT,
    ST_DIV,
    ST_NEXT,
    ST_ORD,
    ST_OLD,
    ST_OWAIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic              load_we;
    logic [CNT_W-1:0]  load_idx;
    logic [SIZE_W-1:0] n;
    logic [IDX_W-1:0]  i;
    logic [IDX_W-1:0]  j;
    logic [IDX_W-1:0]  k;
    logic              rd_en;
    logic              mul_en;
    logic              acc_clr;
    logic              acc_en;
    logic              sub_en;
    logic              sqrt_start;
    logic              div_start;
    logic              wr_l;
    logic              wr_diag;
    logic              out_load;
    logic              out_zero;
    logic              out_last;
    logic              out_err;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic nonpos;
    logic done;
    logic out_taken;
  } sts_t;

endpackage

>>> rtl/chol_ctrl.sv
// ----------------------------------------------------------------------------
// chol_ctrl
// Sequencer: load counting, column/row/term loops and output ordering.
// ----------------------------------------------------------------------------
module chol_ctrl #(
  parameter int MAX_N = chol_pkg::MAX_N_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [chol_pkg::SIZE_W-1:0] size_used,
  input  logic                       in_valid,
  input  logic                       in_first,
  output logic                       in_stall,
  input  chol_pkg::sts_t             sts,
  output chol_pkg::cmd_t             cmd
);

  chol_pkg::state_t              state_r, state_nxt;
  logic [chol_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [chol_pkg::SIZE_W-1:0]   n_r, n_nxt;
  logic [chol_pkg::IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic                          err_r, err_nxt;
  logic [chol_pkg::SIZE_W-1:0]   ecol_r, ecol_nxt;
  logic [chol_pkg::SIZE_W-1:0]   nuse;
  logic [chol_pkg::CNT_W-1:0]    total, idx;
  logic [chol_pkg::SIZE_W-1:0]   i_w, j_w, k_w;

  // clamp the configured order
  always_comb begin
    if (size_used == '0) begin
      nuse = chol_pkg::SIZE_W'(1);
    end else if (size_used > chol_pkg::SIZE_W'(MAX_N)) begin
      nuse = chol_pkg::SIZE_W'(MAX_N);
    end else begin
      nuse = size_used;
    end
  end

  assign total = chol_pkg::CNT_W'(nuse) * chol_pkg::CNT_W'(nuse);
  assign idx   = (in_first || cnt_r >= total) ? '0 : cnt_r;
  assign i_w   = {1'b0, i_r};
  assign j_w   = {1'b0, j_r};
  assign k_w   = {1'b0, k_r};
  assign in_stall = (state_r != chol_pkg::ST_LOAD);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chol_pkg::ST_LOAD;
      cnt_r   <= '0;
      n_r     <= chol_pkg::SIZE_RESET;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      err_r   <= 1'b0;
      ecol_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      err_r   <= err_nxt;
      ecol_r  <= ecol_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    err_nxt   = err_r;
    ecol_nxt  = ecol_r;
    cmd            = '0;
    cmd.n          = n_r;
    cmd.i          = i_r;
    cmd.j          = j_r;
    cmd.k          = k_r;
    cmd.load_idx   = idx;
    cmd.out_err    = err_r;
    case (state_r)
      chol_pkg::ST_LOAD: begin
        cmd.n = nuse;
        if (in_valid) begin
          cmd.load_we = 1'b1;
          cnt_nxt = idx + chol_pkg::CNT_W'(1);
          if (idx + chol_pkg::CNT_W'(1) == total) begin
            cnt_nxt     = '0;
            n_nxt       = nuse;
            i_nxt       = '0;
            j_nxt       = '0;
            k_nxt       = '0;
            err_nxt     = 1'b0;
            ecol_nxt    = nuse;
            cmd.acc_clr = 1'b1;
            state_nxt   = chol_pkg::ST_MRD;
          end
        end
      end
      chol_pkg::ST_MRD: begin
        if (k_r == j_r) begin
          state_nxt = chol_pkg::ST_ARD;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = chol_pkg::ST_MMUL;
        end
      end
      chol_pkg::ST_MMUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = chol_pkg::ST_MACC;
      end
      chol_pkg::ST_MACC: begin
        cmd.acc_en = 1'b1;
        k_nxt      = k_r + 1'b1;
        state_nxt  = chol_pkg::ST_MRD;
      end
      chol_pkg::ST_ARD: begin
        cmd.rd_en = 1'b1;
        state_nxt = chol_pkg::ST_ASUB;
      end
      chol_pkg::ST_ASUB: begin
        cmd.sub_en = 1'b1;
        state_nxt  = chol_pkg::ST_CHK;
      end
      chol_pkg::ST_CHK: begin
        if (i_r == j_r) begin
          if (sts.nonpos) begin
            err_nxt   = 1'b1;
            ecol_nxt  = j_w;
            i_nxt     = '0;
            k_nxt     = '0;
            state_nxt = chol_pkg::ST_ORD;
          end else begin
            cmd.sqrt_start = 1'b1;
            state_nxt      = chol_pkg::ST_SQRT;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = chol_pkg::ST_DIV;
        end
      end
      chol_pkg::ST_SQRT: begin
        if (sts.done) begin
          cmd.wr_l    = 1'b1;
          cmd.wr_diag = 1'b1;
          state_nxt   = chol_pkg::ST_NEXT;
        end
      end
      chol_pkg::ST_DIV: begin
        if (sts.done) begin
          cmd.wr_l  = 1'b1;
          state_nxt = chol_pkg::ST_NEXT;
        end
      end
      chol_pkg::ST_NEXT: begin
        cmd.acc_clr = 1'b1;
        k_nxt       = '0;
        state_nxt   = chol_pkg::ST_MRD;
        if (i_w + 1'b1 == n_r) begin
          if (j_w + 1'b1 == n_r) begin
            i_nxt     = '0;
            state_nxt = chol_pkg::ST_ORD;
          end else begin
            j_nxt = j_r + 1'b1;
            i_nxt = j_r + 1'b1;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      chol_pkg::ST_ORD: begin
        cmd.rd_en = 1'b1;
        state_nxt = chol_pkg::ST_OLD;
      end
      chol_pkg::ST_OLD: begin
        cmd.out_load = 1'b1;
        cmd.out_zero = (k_r > i_r) || (k_w >= ecol_r);
        cmd.out_last = (i_w + 1'b1 == n_r) && (k_w + 1'b1 == n_r);
        state_nxt    = chol_pkg::ST_OWAIT;
      end
      chol_pkg::ST_OWAIT: begin
        if (sts.out_taken) begin
          state_nxt = chol_pkg::ST_ORD;
          if (k_w + 1'b1 == n_r) begin
            k_nxt = '0;
            if (i_w + 1'b1 == n_r) begin
              i_nxt     = '0;
              state_nxt = chol_pkg::ST_LOAD;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = chol_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

>>> rtl/chol_dp.sv
// ----------------------------------------------------------------------------
// chol_dp
// Datapath: matrix and factor memories, multiply-accumulate, iterative
// square root and divider, output register.
// ----------------------------------------------------------------------------
module chol_dp #(
  parameter int MAX_N = chol_pkg::MAX_N_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  chol_pkg::cmd_t                     cmd,
  output chol_pkg::sts_t                     sts,
  input  logic signed [chol_pkg::DATA_W-1:0] in_a_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [chol_pkg::DATA_W-1:0] out_l_value,
  output logic [chol_pkg::IDX_W-1:0]         out_row_index,
  output logic [chol_pkg::IDX_W-1:0]         out_col_index,
  output logic                               out_not_pos_def,
  output logic                               out_last
);

  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = chol_pkg::DATA_W;
  localparam int WW    = chol_pkg::WIDE_W;

  logic signed [DW-1:0] a_mem [DEPTH];
  logic signed [DW-1:0] l_mem [DEPTH];
  logic signed [DW-1:0] a_rd_r, la_rd_r, lb_rd_r;
  logic [AW-1:0]        a_waddr, a_raddr, la_addr, lb_addr, l_waddr;
  logic signed [WW-1:0] prod_r, acc_r, num_r, a_wide;
  logic [DW-1:0]        d_r;
  logic [WW-1:0]        sh_r;
  logic [34:0]          rem_r;
  logic [DW-1:0]        root_r;
  logic [6:0]           it_cnt_r;
  logic                 busy_r, sqrt_mode_r, neg_r;
  logic [34:0]          sq_rs, sq_trial;
  logic [32:0]          dv_rs;
  logic [DW-1:0]        d_sat, q_sat, wr_data;
  logic                 done;

  // saturating 64-bit add and subtract
  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                  logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = b[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                  logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  // addresses
  assign a_waddr = AW'(cmd.load_idx);
  assign a_raddr = AW'(cmd.i) * AW'(cmd.n) + AW'(cmd.j);
  assign la_addr = AW'(cmd.i * MAX_N + cmd.k);
  assign lb_addr = AW'(cmd.j * MAX_N + cmd.k);
  assign l_waddr = AW'(cmd.i * MAX_N + cmd.j);

  // matrix store
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      a_mem[a_waddr] <= in_a_value;
    end
    if (cmd.rd_en) begin
      a_rd_r <= a_mem[a_raddr];
    end
  end

  // factor store
  always_ff @(posedge clk) begin
    if (cmd.wr_l) begin
      l_mem[l_waddr] <= wr_data;
    end
    if (cmd.rd_en) begin
      la_rd_r <= l_mem[la_addr];
      lb_rd_r <= l_mem[lb_addr];
    end
  end

  // multiply-accumulate and pivot/numerator
  assign a_wide = {{16{a_rd_r[DW-1]}}, a_rd_r, 16'b0};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= la_rd_r * lb_rd_r;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= sat_add(acc_r, prod_r);
    end
    if (cmd.sub_en) begin
      num_r <= sat_sub(a_wide, acc_r);
    end
    if (cmd.wr_diag) begin
      d_r <= d_sat;
    end
  end

  // one root digit or one quotient bit per cycle
  assign sq_rs    = {rem_r[32:0], sh_r[WW-1:WW-2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign dv_rs    = {rem_r[31:0], sh_r[WW-1]};
  assign done     = busy_r && (it_cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      it_cnt_r <= '0;
    end else if (cmd.sqrt_start) begin
      busy_r   <= 1'b1;
      it_cnt_r <= 7'd32;
    end else if (cmd.div_start) begin
      busy_r   <= 1'b1;
      it_cnt_r <= 7'd64;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      it_cnt_r <= it_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sqrt_mode_r <= 1'b1;
      sh_r        <= num_r;
      rem_r       <= '0;
      root_r      <= '0;
    end else if (cmd.div_start) begin
      sqrt_mode_r <= 1'b0;
      neg_r       <= num_r[WW-1];
      sh_r        <= num_r[WW-1] ? -num_r : num_r;
      rem_r       <= '0;
    end else if (busy_r && !done) begin
      if (sqrt_mode_r) begin
        sh_r <= {sh_r[WW-3:0], 2'b00};
        if (sq_rs >= sq_trial) begin
          rem_r  <= sq_rs - sq_trial;
          root_r <= {root_r[DW-2:0], 1'b1};
        end else begin
          rem_r  <= sq_rs;
          root_r <= {root_r[DW-2:0], 1'b0};
        end
      end else begin
        if (dv_rs >= {1'b0, d_r}) begin
          rem_r <= {2'b00, dv_rs - {1'b0, d_r}};
          sh_r  <= {sh_r[WW-2:0], 1'b1};
        end else begin
          rem_r <= {2'b00, dv_rs};
          sh_r  <= {sh_r[WW-2:0], 1'b0};
        end
      end
    end
  end

  // saturation of the root and the quotient
  always_comb begin
    d_sat = root_r[DW-1] ? {1'b0, {(DW-1){1'b1}}} : root_r;
    if (neg_r) begin
      if (sh_r > WW'(64'h8000_0000)) begin
        q_sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
        q_sat = -sh_r[DW-1:0];
      end
    end else begin
      if (sh_r > WW'(64'h7FFF_FFFF)) begin
        q_sat = {1'b0, {(DW-1){1'b1}}};
      end else begin
        q_sat = sh_r[DW-1:0];
      end
    end
    wr_data = cmd.wr_diag ? d_sat : q_sat;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_l_value     <= cmd.out_zero ? '0 : la_rd_r;
      out_row_index   <= cmd.i;
      out_col_index   <= cmd.k;
      out_not_pos_def <= cmd.out_err;
      out_last        <= cmd.out_last;
    end
  end

  assign sts.nonpos    = num_r[WW-1] || (num_r == '0);
  assign sts.done      = done;
  assign sts.out_taken = out_valid && !out_stall;

endmodule

>>> rtl/cholesky_decomposition.sv
// Flow: the n*n entries of A are loaded, then each factor entry runs its control
// states and its inner product terms, then the root unit for a diagonal or the
// divider for an entry below it; then every entry of L is emitted. One matrix at a time.
// The root/divide unit is shared by the diagonal and the entries below it.
// Reset (synchronous, active low) clears the load count, the error flag and the
// output valid, and sets the order to 8; memories are not cleared.
// ----------------------------------------------------------------------------
// cholesky_decomposition
// Lower-triangular Cholesky factor of a Q16.16 symmetric matrix.
// ----------------------------------------------------------------------------
module cholesky_decomposition #(
  parameter int MAX_N = chol_pkg::MAX_N_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [chol_pkg::SIZE_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [chol_pkg::DATA_W-1:0]  in_a_value,
  input  logic                                in_first,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [chol_pkg::DATA_W-1:0]  out_l_value,
  output logic [chol_pkg::IDX_W-1:0]          out_row_index,
  output logic [chol_pkg::IDX_W-1:0]          out_col_index,
  output logic                                out_not_pos_def,
  output logic                                out_last
);

  logic [chol_pkg::SIZE_W-1:0] size_used_r;
  chol_pkg::cmd_t              cmd;
  chol_pkg::sts_t              sts;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_used_r <= chol_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_used_r <= cfg_wdata;
    end
  end

  chol_ctrl #(.MAX_N(MAX_N)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .size_used (size_used_r),
    .in_valid  (in_valid),
    .in_first  (in_first),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  chol_dp #(.MAX_N(MAX_N)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_a_value      (in_a_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_l_value     (out_l_value),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_not_pos_def (out_not_pos_def),
    .out_last        (out_last)
  );

endmodule
